### hw/rtl/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a property holds at every clock edge out of reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// assert that one condition implies another in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### hw/rtl/hpit_pkg.sv
// ---------------------------------------------------------------------------
// hpit_pkg
// shared types and constants of the hashed page index table
// ---------------------------------------------------------------------------
package hpit_pkg;
	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [2:0] ST_FOUND   = 3'd0;
	localparam logic [2:0] ST_CREATED = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_REMOVED = 3'd3;
	localparam logic [2:0] ST_MISSED  = 3'd4;
	localparam logic REQ_GET    = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture request, start product
		logic hash;       // multiply stage 2
		logic head_rd;    // read bucket head
		logic ent_rd;     // issue entry read for cur
		logic step;       // cur <= link, prev <= cur
		logic create;     // write new entry and head
		logic pop_rd;     // read free stack top
		logic unlink;     // unlink cur
		logic result;     // load result register
		logic [2:0] status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic have;
		logic hit;
		logic pool_empty;
		logic bound;
		logic req_type;
	} sts_t;
endpackage

### hw/rtl/hpit_ctrl.sv
// ---------------------------------------------------------------------------
// hpit_ctrl
// request sequencer of the hashed page index table
// ---------------------------------------------------------------------------
module hpit_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             out_busy,
	input  hpit_pkg::sts_t   sts,
	output logic             idle,
	output hpit_pkg::cmd_t   cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_HEAD  = 4'd2;
	localparam logic [3:0] S_HWAIT = 4'd3;
	localparam logic [3:0] S_RD    = 4'd4;
	localparam logic [3:0] S_CMP   = 4'd5;
	localparam logic [3:0] S_POP   = 4'd6;
	localparam logic [3:0] S_MK    = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q, state_d;
	logic [2:0] status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= hpit_pkg::ST_FOUND;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		cmd      = '0;
		cmd.status = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.hash = 1'b1;
				state_d  = S_HEAD;
			end
			S_HEAD: begin
				cmd.head_rd = 1'b1;
				state_d     = S_HWAIT;
			end
			S_HWAIT: begin
				cmd.ent_rd = 1'b1;
				state_d    = S_CMP;
			end
			S_RD: begin
				cmd.ent_rd = 1'b1;
				state_d    = S_CMP;
			end
			S_CMP: begin
				if (sts.have && sts.hit) begin
					if (sts.req_type == hpit_pkg::REQ_REMOVE) begin
						cmd.unlink = 1'b1;
						status_d   = hpit_pkg::ST_REMOVED;
					end else begin
						status_d = hpit_pkg::ST_FOUND;
					end
					state_d = S_DONE;
				end else if (sts.have && !sts.bound) begin
					cmd.step = 1'b1;
					state_d  = S_RD;
				end else if (sts.req_type == hpit_pkg::REQ_REMOVE) begin
					status_d = hpit_pkg::ST_MISSED;
					state_d  = S_DONE;
				end else if (sts.pool_empty) begin
					status_d = hpit_pkg::ST_FULL;
					state_d  = S_DONE;
				end else begin
					cmd.pop_rd = 1'b1;
					state_d    = S_POP;
				end
			end
			S_POP: begin
				state_d = S_MK;
			end
			S_MK: begin
				cmd.create = 1'b1;
				status_d   = hpit_pkg::ST_CREATED;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_busy) begin
					cmd.result = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### hw/rtl/hpit_dp.sv
// ---------------------------------------------------------------------------
// hpit_dp
// hash, entry memories, free stack and chain walk of the table
// ---------------------------------------------------------------------------
module hpit_dp #(
	parameter int BUCKET_BITS = 10,
	parameter int ENTRIES     = 1024,
	parameter int PAGE_SHIFT  = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hpit_pkg::cmd_t        cmd,
	input  logic                  req_type,
	input  logic [63:0]           page_base,
	input  logic [15:0]           device_id,
	output hpit_pkg::sts_t        sts,
	output logic                  init_done,
	output logic [2:0]            res_status,
	output logic [9:0]            res_index,
	output logic [15:0]           res_device
);
	localparam int NB = 1 << BUCKET_BITS;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int NI = (NB > ENTRIES) ? NB : ENTRIES;
	localparam int NIW = $clog2(NI) + 1;

	// head and link words hold a valid bit over the slot
	logic [IW:0]  head_mem [NB];
	logic [63:0]  key_mem [ENTRIES];
	logic [15:0]  dev_mem [ENTRIES];
	logic [IW:0]  link_mem [ENTRIES];
	logic [IW-1:0] stk_mem [ENTRIES];

	logic          req_q;
	logic [63:0]   base_q;
	logic [15:0]   dev_q;
	logic [31:0]   pl_lo_q, pl_hi_q, ph_lo_q;
	logic [BUCKET_BITS-1:0] bkt_q;
	logic [IW-1:0] cur_q, prev_q, slot_q;
	logic          have_q, prev_vld_q;
	logic [IW:0]   head_rd_q;
	logic [63:0]   key_rd_q;
	logic [15:0]   dev_rd_q;
	logic [IW:0]   link_rd_q;
	logic [IW-1:0] stk_rd_q;
	logic [CW-1:0] free_cnt_q;
	logic [CW-1:0] steps_q;
	logic [NIW-1:0] init_cnt_q;
	logic          init_q;
	logic [2:0]    status_q;
	logic [9:0]    index_q;
	logic [15:0]   device_q;
	logic          rd_pend_q;

	logic [63:0] page;
	logic [63:0] pll;
	logic [31:0] hsum;
	logic [IW-1:0] rd_addr;
	logic          mem_wr;
	logic [IW-1:0] stk_waddr;
	logic [IW-1:0] stk_wdata;
	logic [IW-1:0] top_addr;

	assign page = page_base >> PAGE_SHIFT;
	assign pll  = {32'd0, page[31:0]} * {32'd0, hpit_pkg::GOLDEN[31:0]};
	assign hsum = pl_lo_q + pl_hi_q + ph_lo_q;

	// reset pass: clear bucket heads, fill the free stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
			init_q     <= 1'b0;
		end else if (!init_q) begin
			init_cnt_q <= init_cnt_q + 1'b1;
			if (init_cnt_q == NIW'(NI - 1))
				init_q <= 1'b1;
		end
	end
	assign init_done = init_q;

	assign stk_waddr = !init_q ? init_cnt_q[IW-1:0] : free_cnt_q[IW-1:0];
	assign stk_wdata = !init_q ? init_cnt_q[IW-1:0] : cur_q;
	assign mem_wr    = (!init_q && (init_cnt_q < NIW'(ENTRIES))) ||
		(init_q && cmd.unlink && (free_cnt_q < CW'(ENTRIES)));
	assign top_addr  = IW'(free_cnt_q - 1'b1);

	always_ff @(posedge clk) begin
		if (mem_wr)
			stk_mem[stk_waddr] <= stk_wdata;
		if (cmd.pop_rd)
			stk_rd_q <= stk_mem[top_addr];
	end

	// hash: page * golden mod 2^64, split into 32x32 partial products
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			base_q  <= page_base;
			dev_q   <= device_id;
			pl_lo_q <= pll[63:32];
			pl_hi_q <= page[31:0] * hpit_pkg::GOLDEN[63:32];
			ph_lo_q <= page[63:32] * hpit_pkg::GOLDEN[31:0];
		end
		if (cmd.hash)
			bkt_q <= hsum[31 -: BUCKET_BITS];
	end

	// bucket heads
	always_ff @(posedge clk) begin
		if (cmd.head_rd)
			head_rd_q <= head_mem[bkt_q];
		if (!init_q) begin
			if (init_cnt_q < NIW'(NB))
				head_mem[init_cnt_q[BUCKET_BITS-1:0]] <= '0;
		end else if (cmd.create)
			head_mem[bkt_q] <= {1'b1, slot_q};
		else if (cmd.unlink && !prev_vld_q)
			head_mem[bkt_q] <= link_rd_q;
	end

	// walk registers
	assign rd_addr = rd_pend_q ? head_rd_q[IW-1:0] : cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			prev_vld_q <= 1'b0;
			rd_pend_q  <= 1'b0;
			steps_q    <= '0;
			free_cnt_q <= CW'(ENTRIES);
		end else begin
			if (cmd.head_rd) begin
				rd_pend_q  <= 1'b1;
				prev_vld_q <= 1'b0;
				steps_q    <= '0;
			end
			if (cmd.ent_rd && rd_pend_q) begin
				rd_pend_q <= 1'b0;
				have_q    <= head_rd_q[IW];
			end
			if (cmd.step) begin
				prev_vld_q <= 1'b1;
				have_q     <= link_rd_q[IW];
				steps_q    <= steps_q + 1'b1;
			end
			if (cmd.create)
				free_cnt_q <= free_cnt_q - 1'b1;
			else if (mem_wr && init_q)
				free_cnt_q <= free_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ent_rd) begin
			cur_q    <= rd_addr;
			key_rd_q <= key_mem[rd_addr];
			dev_rd_q <= dev_mem[rd_addr];
			link_rd_q <= link_mem[rd_addr];
		end
		if (cmd.step) begin
			prev_q <= cur_q;
			cur_q  <= link_rd_q[IW-1:0];
		end
		if (cmd.create) begin
			key_mem[slot_q]  <= base_q;
			dev_mem[slot_q]  <= dev_q;
			link_mem[slot_q] <= head_rd_q;
		end else if (cmd.unlink && prev_vld_q) begin
			link_mem[prev_q] <= link_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.create)
			slot_q <= slot_q;
		else
			slot_q <= stk_rd_q;
	end

	assign sts.have       = have_q;
	assign sts.hit        = (key_rd_q == base_q);
	assign sts.pool_empty = (free_cnt_q == '0);
	assign sts.bound      = (steps_q == CW'(ENTRIES - 1));
	assign sts.req_type   = req_q;

	// result register
	always_ff @(posedge clk) begin
		if (cmd.result) begin
			status_q <= cmd.status;
			if (cmd.status == hpit_pkg::ST_FOUND) begin
				index_q  <= 10'(cur_q);
				device_q <= dev_rd_q;
			end else if (cmd.status == hpit_pkg::ST_CREATED) begin
				index_q  <= 10'(slot_q);
				device_q <= dev_q;
			end else begin
				index_q  <= '0;
				device_q <= '0;
			end
		end
	end

	assign res_status = status_q;
	assign res_index  = index_q;
	assign res_device = device_q;
endmodule

### hw/rtl/hashed_page_index_table.sv
// ---------------------------------------------------------------------------
// hashed_page_index_table
// chained hash table of page bases with a lifo pool of entries
// ---------------------------------------------------------------------------
// channel  signals                              role
// in       in_valid/in_ready, req_type..        request transaction
// out      out_valid/out_ready, status..        one result per request
// result and in_ready return after the hash, head read and first compare, plus an entry
// read and compare per further chain entry compared, plus a stack pop and a write on create
// after reset the bucket heads are cleared and the free stack is filled
// while in_ready is low
// a held result stalls only the next request's final step
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module hashed_page_index_table #(
	parameter int BUCKET_BITS = 10,
	parameter int ENTRIES     = 1024,
	parameter int PAGE_SHIFT  = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [63:0] page_base,
	input  logic [15:0] device_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [9:0]  entry_index,
	output logic [15:0] entry_device
);
	hpit_pkg::cmd_t cmd;
	hpit_pkg::sts_t sts;
	logic idle, init_done, in_fire, out_q;

	assign in_ready = idle && init_done;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_q <= 1'b0;
		else if (cmd.result)
			out_q <= 1'b1;
		else if (out_ready)
			out_q <= 1'b0;
	end
	assign out_valid = out_q;

	hpit_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(out_q && !out_ready), .sts(sts), .idle(idle), .cmd(cmd)
	);

	hpit_dp #(.BUCKET_BITS(BUCKET_BITS), .ENTRIES(ENTRIES), .PAGE_SHIFT(PAGE_SHIFT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req_type(req_type),
		.page_base(page_base), .device_id(device_id), .sts(sts),
		.init_done(init_done), .res_status(status), .res_index(entry_index),
		.res_device(entry_device)
	);

	`CHK_ALWAYS(a_ready_idle, clk, arst_n, !(in_ready && !idle), "ready outside idle")
	`CHK_NEXT(a_out_set, clk, arst_n, cmd.result, out_valid, "result not shown")
	`CHK_ALWAYS(a_no_overrun, clk, arst_n, !(cmd.result && out_valid && !out_ready),
		"result overwrites held output")
endmodule

### sim/tb_hashed_page_index_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_hashed_page_index_table
// Random and directed get-or-create and remove transactions against a
// behavioral hash table with a lifo slot pool; every result is compared in
// order with the table's own prediction.
// ---------------------------------------------------------------------------
module tb_hashed_page_index_table;
	localparam int BUCKET_BITS = 10;
	localparam int ENTRIES     = 1024;
	localparam int PAGE_SHIFT  = 18;
	localparam int NBUCKETS    = 1 << BUCKET_BITS;
	localparam int N_RANDOM    = 220;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  index;
		logic [15:0] device;
	} page_result_t;

	int errors = 0;

	task automatic report(input string what, input page_result_t got, input page_result_t exp);
		$display("mismatch %s: got st=%0d idx=%0d dev=%h exp st=%0d idx=%0d dev=%h", what,
			got.status, got.index, got.device, exp.status, exp.index, exp.device);
		errors++;
	endtask

	class page_table_scoreboard;
		bit          head_ok[NBUCKETS];
		int          head_at[NBUCKETS];
		logic [63:0] key[ENTRIES];
		logic [15:0] dev[ENTRIES];
		bit          next_ok[ENTRIES];
		int          next_at[ENTRIES];
		int          free_slots[ENTRIES];
		int          free_count;
		page_result_t pending[$];
		int n_found, n_created, n_full, n_removed, n_missed;

		function new();
			for (int k = 0; k < ENTRIES; k++) free_slots[k] = k;
			free_count = ENTRIES;
		endfunction

		function int bucket(input logic [63:0] base);
			logic [63:0] prod;
			prod = (base >> PAGE_SHIFT) * hpit_pkg::GOLDEN;
			return int'(prod >> (64 - BUCKET_BITS));
		endfunction

		function void note_request(input logic rt, input logic [63:0] base,
				input logic [15:0] did);
			int b, cur, prev, steps;
			bit have, prev_ok, hit;
			page_result_t r;
			b = bucket(base);
			have = head_ok[b];
			cur = head_at[b];
			prev_ok = 0; prev = 0; steps = 0; hit = 0;
			r = '0;
			while (have && steps < ENTRIES) begin
				if (key[cur] == base) begin
					hit = 1;
					break;
				end
				prev_ok = 1; prev = cur;
				have = next_ok[cur]; cur = next_at[cur];
				steps++;
			end
			if (rt == hpit_pkg::REQ_GET) begin
				if (hit) begin
					r.status = hpit_pkg::ST_FOUND; r.index = 10'(cur); r.device = dev[cur];
					n_found++;
				end else if (free_count == 0) begin
					r.status = hpit_pkg::ST_FULL; n_full++;
				end else begin
					int s;
					free_count--;
					s = free_slots[free_count];
					key[s] = base; dev[s] = did;
					next_ok[s] = head_ok[b]; next_at[s] = head_at[b];
					head_ok[b] = 1; head_at[b] = s;
					r.status = hpit_pkg::ST_CREATED; r.index = 10'(s); r.device = did;
					n_created++;
				end
			end else if (hit) begin
				if (prev_ok) begin
					next_ok[prev] = next_ok[cur]; next_at[prev] = next_at[cur];
				end else begin
					head_ok[b] = next_ok[cur]; head_at[b] = next_at[cur];
				end
				free_slots[free_count] = cur;
				free_count++;
				r.status = hpit_pkg::ST_REMOVED; n_removed++;
			end else begin
				r.status = hpit_pkg::ST_MISSED; n_missed++;
			end
			pending.push_back(r);
		endfunction

		task check_result(input page_result_t got);
			page_result_t exp;
			if (pending.size() == 0) begin
				report("unexpected", got, '0);
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) report("status", got, exp);
			if (got.index !== exp.index) report("entry_index", got, exp);
			if (got.device !== exp.device) report("entry_device", got, exp);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, req_type = 0, out_valid, out_ready = 0;
	logic [63:0] page_base = '0;
	logic [15:0] device_id = '0;
	logic [2:0] status;
	logic [9:0] entry_index;
	logic [15:0] entry_device;

	hashed_page_index_table #(.BUCKET_BITS(BUCKET_BITS), .ENTRIES(ENTRIES),
			.PAGE_SHIFT(PAGE_SHIFT)) dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .page_base(page_base), .device_id(device_id),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.entry_index(entry_index), .entry_device(entry_device)
	);

	page_table_scoreboard sb = new();
	logic [63:0] used_bases[$];
	bit long_hold = 0, hold_done = 0, stim_done = 0, no_gaps = 0;
	longint cycles = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	// one transaction on the request side
	task automatic send(input logic rt, input logic [63:0] base, input logic [15:0] did);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1; req_type <= rt; page_base <= base; device_id <= did;
		do @(posedge clk); while (!in_ready);
		sb.note_request(rt, base, did);
		used_bases.push_back(base);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] pick_base();
		int r;
		r = $urandom_range(0, 9);
		if (used_bases.size() > 0 && r < 6)
			return used_bases[$urandom_range(0, used_bases.size() - 1)];
		if (r < 8)
			return (64'($urandom_range(0, 255)) << 18) | (64'($urandom_range(0, 1)) << 63);
		return rand64();
	endfunction

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [63:0] b;
		@(posedge clk iff arst_n);
		// directed: extremes, both requests, missed remove, full pool later
		send(hpit_pkg::REQ_REMOVE, 64'h0, 16'h0);
		send(hpit_pkg::REQ_GET, 64'h0, 16'hFFFF);
		send(hpit_pkg::REQ_GET, 64'h0, 16'h1234);
		send(hpit_pkg::REQ_GET, '1, 16'h0);
		send(hpit_pkg::REQ_GET, 64'h8000_0000_0000_0000, 16'hA5A5);
		send(hpit_pkg::REQ_GET, 64'h0000_0000_0003_FFFF, 16'h5A5A);
		send(hpit_pkg::REQ_GET, 64'h0000_0000_0004_0000, 16'h0001);
		send(hpit_pkg::REQ_REMOVE, 64'h0000_0000_0003_FFFF, 16'h0);
		send(hpit_pkg::REQ_REMOVE, 64'h0, 16'hFFFF);
		send(hpit_pkg::REQ_REMOVE, 64'h0, 16'h0);
		send(hpit_pkg::REQ_GET, 64'h5555_5555_5555_5555, 16'h5555);
		send(hpit_pkg::REQ_GET, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA);
		send(hpit_pkg::REQ_GET, 64'h0, 16'h7777);
		send(hpit_pkg::REQ_REMOVE, '1, 16'h0);
		send(hpit_pkg::REQ_GET, 64'h0000_0000_0003_FFFF, 16'h0);
		// sender pauses until everything has come back
		wait_drained();
		// receiver long hold while requests keep flowing
		fork
			begin
				long_hold = 1;
				repeat (400) @(posedge clk);
				long_hold = 0;
				hold_done = 1;
			end
			begin
				no_gaps = 1;
				for (int i = 0; i < 30; i++)
					send(1'($urandom_range(0, 1)), pick_base(), 16'($urandom()));
				no_gaps = 0;
			end
		join
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 80) no_gaps = 1;
			if (i == 140) no_gaps = 0;
			send($urandom_range(0, 3) == 0, pick_base(), 16'($urandom()));
		end
		wait_drained();
		// fill the pool, hit full, then remove 60 of the filled bases
		for (int i = 0; i < ENTRIES + 8; i++) begin
			no_gaps = 1;
			b = rand64();
			send(hpit_pkg::REQ_GET, b, 16'($urandom()));
		end
		send(hpit_pkg::REQ_GET, 64'h0123_4567_89AB_CDEF, 16'hBEEF);
		for (int i = 0; i < 60; i++)
			send(hpit_pkg::REQ_REMOVE, used_bases[used_bases.size() - 2 - i], 16'h0);
		for (int i = 0; i < 40; i++)
			send(1'($urandom_range(0, 1)), pick_base(), 16'($urandom()));
		in_valid <= 0;
		stim_done = 1;
	end

	// result side with random stalls
	initial begin : receiver
		int stall;
		page_result_t got;
		@(posedge clk iff arst_n);
		forever begin
			stall = $urandom_range(0, 16);
			if ($urandom_range(0, 2) == 0) stall = 0;
			if (stall > 0 || long_hold) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
				while (long_hold) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!(out_valid && out_ready));
			got.status = status; got.index = entry_index; got.device = entry_device;
			sb.check_result(got);
		end
	end

	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("tb_hashed_page_index_table failed");
				$finish;
			end
		end
	end

	initial begin : finish_run
		wait (stim_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered: found %0d, created %0d, pool full %0d, removed %0d, missed %0d",
			sb.n_found, sb.n_created, sb.n_full, sb.n_removed, sb.n_missed);
		$display("long output hold exercised: %0d, mismatches: %0d", hold_done, errors);
		if (errors == 0) begin
			$display("tb_hashed_page_index_table passed");
		end else begin
			$display("tb_hashed_page_index_table failed");
		end
		$finish;
	end
endmodule
